### sv/ber_pkg.sv
// ber_pkg: widths, opcodes, multiplier selects, move codes and the control/status structs
// of the ellipse rasterizer. No dependencies; imported by every module.
`default_nettype none

package ber_pkg;

  // field widths
  localparam int AXIS_BITS  = 11;
  localparam int COORD_BITS = 12;
  localparam int OUT_BITS   = 13;

  // derived datapath widths
  localparam int SQ_BITS    = 2 * AXIS_BITS;      // squared semi-axis
  localparam int OFF_BITS   = AXIS_BITS + 1;      // x offset, reaches a + 1
  localparam int Y_BITS     = AXIS_BITS + 2;      // signed y offset, reaches -1
  localparam int MUL_L_BITS = SQ_BITS + 1;        // signed left multiplier operand
  localparam int PROD_BITS  = MUL_L_BITS + Y_BITS;
  localparam int ERR_BITS   = PROD_BITS;
  localparam int DEC_BITS   = ERR_BITS + 3;       // headroom for decision sums
  localparam int CALC_BITS  = 32;                 // coordinate sums before masking

  // opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // multiplier operand selects
  localparam logic [1:0] MUL_SQUARE = 2'd0;
  localparam logic [1:0] MUL_STEP   = 2'd1;
  localparam logic [1:0] MUL_NEXT   = 2'd2;

  // move codes
  localparam logic [1:0] MOVE_HORIZ = 2'd0;
  localparam logic [1:0] MOVE_VERT  = 2'd1;
  localparam logic [1:0] MOVE_DIAG  = 2'd2;

  typedef struct packed {
    logic       load_start;
    logic       square_en;
    logic       prod_en;
    logic [1:0] mul_sel;
    logic       decide;
    logic       init_err;
    logic       update;
  } ber_cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } ber_sts_t;

endpackage

`default_nettype wire

### sv/ber_ctrl.sv
// ber_ctrl: sequencer of the ellipse rasterizer, start and step phases.
// Depends on ber_pkg; drives commands into ber_dp.
`default_nettype none

module ber_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire               opcode,
  input  ber_pkg::ber_sts_t sts,
  output ber_pkg::ber_cmd_t cmd
);
  import ber_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SQUARE = 3'd1;
  localparam logic [2:0] ST_PROD   = 3'd2;
  localparam logic [2:0] ST_INIT   = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;
  localparam logic [2:0] ST_NEXT   = 3'd5;
  localparam logic [2:0] ST_UPDATE = 3'd6;

  logic [2:0] state, state_next;
  logic       active, active_next;

  // next state and commands
  always_comb begin
    state_next  = state;
    active_next = active;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.mul_sel = MUL_STEP;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.prod_en = 1'b1;
        if (in_valid) begin
          if (opcode == OP_START) begin
            cmd.load_start = 1'b1;
            active_next    = 1'b0;
            state_next     = ST_SQUARE;
          end else if (active) begin
            state_next = ST_DECIDE;
          end
        end
      end
      ST_SQUARE: begin
        cmd.mul_sel   = MUL_SQUARE;
        cmd.square_en = 1'b1;
        state_next    = ST_PROD;
      end
      ST_PROD: begin
        cmd.prod_en = 1'b1;
        state_next  = ST_INIT;
      end
      ST_INIT: begin
        cmd.init_err = 1'b1;
        active_next  = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = ST_NEXT;
      end
      ST_NEXT: begin
        cmd.mul_sel = MUL_NEXT;
        cmd.prod_en = 1'b1;
        state_next  = ST_UPDATE;
      end
      ST_UPDATE: begin
        // wait here while the output register still holds an untaken beat
        if (!sts.out_busy) begin
          cmd.update  = 1'b1;
          active_next = !sts.last;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      active <= 1'b0;
    end else begin
      state  <= state_next;
      active <= active_next;
    end
  end

endmodule

`default_nettype wire

### sv/ber_dp.sv
// ber_dp: datapath of the ellipse rasterizer: two shared multipliers,
// error term, offsets and the output register. Depends on ber_pkg.
`default_nettype none

module ber_dp (
  input  wire                                   clk,
  input  wire                                   rst,
  input  ber_pkg::ber_cmd_t                     cmd,
  output ber_pkg::ber_sts_t                     sts,
  input  wire [ber_pkg::COORD_BITS-1:0]         center_x,
  input  wire [ber_pkg::COORD_BITS-1:0]         center_y,
  input  wire [ber_pkg::AXIS_BITS-1:0]          semi_axis_x,
  input  wire [ber_pkg::AXIS_BITS-1:0]          semi_axis_y,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic [ber_pkg::OUT_BITS-1:0]          x_right,
  output logic signed [ber_pkg::OUT_BITS-1:0]   x_left,
  output logic [ber_pkg::OUT_BITS-1:0]          y_down,
  output logic signed [ber_pkg::OUT_BITS-1:0]   y_up,
  output logic                                  last_point
);
  import ber_pkg::*;

  logic [COORD_BITS-1:0]        origin_x, origin_y;
  logic [AXIS_BITS-1:0]         axis_a, axis_b;
  logic [SQ_BITS-1:0]           a2, b2;
  logic [OFF_BITS-1:0]          x, nx;
  logic signed [Y_BITS-1:0]     y, ny;
  logic signed [ERR_BITS-1:0]   err;
  logic signed [PROD_BITS-1:0]  pa, pb;
  logic [1:0]                   move;

  logic signed [MUL_L_BITS-1:0] mla, mlb;
  logic signed [Y_BITS-1:0]     mra, mrb;
  logic signed [PROD_BITS-1:0]  prod_a, prod_b;

  logic signed [DEC_BITS-1:0]   err_w, pa_w, pb_w, a2_w, b2_w;
  logic signed [DEC_BITS-1:0]   d_neg, d_pos, err_upd, err_init;
  logic [1:0]                   move_next;

  // multiplier operand select
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_SQUARE: begin
        mla = $signed(MUL_L_BITS'(axis_a));
        mra = $signed(Y_BITS'(axis_a));
        mlb = $signed(MUL_L_BITS'(axis_b));
        mrb = $signed(Y_BITS'(axis_b));
      end
      MUL_NEXT: begin
        mla = $signed(MUL_L_BITS'(a2));
        mra = ny;
        mlb = $signed(MUL_L_BITS'(b2));
        mrb = $signed(Y_BITS'(nx));
      end
      default: begin
        mla = $signed(MUL_L_BITS'(a2));
        mra = y;
        mlb = $signed(MUL_L_BITS'(b2));
        mrb = $signed(Y_BITS'(x));
      end
    endcase
  end

  assign prod_a = mla * mra;
  assign prod_b = mlb * mrb;

  // widened operands
  assign err_w = DEC_BITS'(err);
  assign pa_w  = DEC_BITS'(pa);
  assign pb_w  = DEC_BITS'(pb);
  assign a2_w  = $signed(DEC_BITS'(a2));
  assign b2_w  = $signed(DEC_BITS'(b2));

  // secondary decision values
  assign d_neg = ((err_w + pa_w) <<< 1) - a2_w;
  assign d_pos = ((err_w - pb_w) <<< 1) - b2_w;

  // move choice from error sign and decision value
  always_comb begin
    priority if (err < 0) begin
      move_next = (d_neg < 0) ? MOVE_HORIZ : MOVE_DIAG;
    end else if (err > 0) begin
      move_next = (d_pos > 0) ? MOVE_VERT : MOVE_DIAG;
    end else begin
      move_next = MOVE_DIAG;
    end
  end

  // error update with products of the moved offsets
  always_comb begin
    unique case (move)
      MOVE_HORIZ: err_upd = err_w + (pb_w <<< 1) + b2_w;
      MOVE_VERT:  err_upd = err_w - (pa_w <<< 1) + a2_w;
      default:    err_upd = err_w + ((pb_w - pa_w) <<< 1) + a2_w + b2_w;
    endcase
  end

  assign err_init = a2_w + b2_w - (pa_w <<< 1);

  // status
  assign sts.last     = ny[Y_BITS-1];
  assign sts.out_busy = out_valid && !out_ready;

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_start) begin
      origin_x <= center_x;
      origin_y <= center_y;
      axis_a   <= semi_axis_x;
      axis_b   <= semi_axis_y;
      x        <= '0;
      y        <= $signed(Y_BITS'(semi_axis_y));
    end
    if (cmd.square_en) begin
      a2 <= SQ_BITS'(prod_a);
      b2 <= SQ_BITS'(prod_b);
    end
    if (cmd.prod_en) begin
      pa <= prod_a;
      pb <= prod_b;
    end
    if (cmd.init_err) begin
      err <= ERR_BITS'(err_init);
    end
    if (cmd.decide) begin
      move <= move_next;
      nx   <= (move_next != MOVE_VERT) ? x + OFF_BITS'(1) : x;
      ny   <= (move_next != MOVE_HORIZ) ? y - $signed(Y_BITS'(1)) : y;
    end
    if (cmd.update) begin
      x   <= nx;
      y   <= ny;
      err <= ERR_BITS'(err_upd);
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      x_right    <= OUT_BITS'(CALC_BITS'(origin_x) + CALC_BITS'(x));
      x_left     <= $signed(OUT_BITS'(CALC_BITS'(origin_x) - CALC_BITS'(x)));
      y_down     <= OUT_BITS'(CALC_BITS'(origin_y) + CALC_BITS'($unsigned(y)));
      y_up       <= $signed(OUT_BITS'(CALC_BITS'(origin_y) - CALC_BITS'($unsigned(y))));
      last_point <= ny[Y_BITS-1];
    end
  end

  // output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### sv/bresenham_ellipse_raster.sv
// bresenham_ellipse_raster: axis-aligned ellipse rasterizer, top level.
// Depends on ber_pkg, ber_ctrl and ber_dp.
//
// Input channel (in_valid/in_ready): opcode 0 loads center and semi-axes
// and produces no output beat; opcode 1 produces one beat per point set
// while an ellipse is running, and nothing when idle.
// Output channel (out_valid/out_ready): the four mirrored coordinates and
// last_point, which marks the final point set; the block then goes idle.
// Sequence: a start beat runs through accept, square both axes, multiply
// a2 by b and form the initial error. A step beat runs through accept with
// the a2*y and b2*x products, decide the move, multiply the moved offsets,
// then update the error and load the output register; the next beat is
// only accepted after that update. The sequence is set by the two shared
// multipliers, each used twice per step.
// Reset clears the sequencer, the running flag and out_valid.
// When the receiver stalls, the block still accepts the next beat; its
// result waits in the update step until the output register is free.
`default_nettype none

module bresenham_ellipse_raster (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire                                 opcode,
  input  wire [ber_pkg::COORD_BITS-1:0]       center_x,
  input  wire [ber_pkg::COORD_BITS-1:0]       center_y,
  input  wire [ber_pkg::AXIS_BITS-1:0]        semi_axis_x,
  input  wire [ber_pkg::AXIS_BITS-1:0]        semi_axis_y,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [ber_pkg::OUT_BITS-1:0]        x_right,
  output logic signed [ber_pkg::OUT_BITS-1:0] x_left,
  output logic [ber_pkg::OUT_BITS-1:0]        y_down,
  output logic signed [ber_pkg::OUT_BITS-1:0] y_up,
  output logic                                last_point
);
  import ber_pkg::*;

  ber_cmd_t cmd;
  ber_sts_t sts;

  // sequencer
  ber_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic and output register
  ber_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .center_x    (center_x),
    .center_y    (center_y),
    .semi_axis_x (semi_axis_x),
    .semi_axis_y (semi_axis_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .x_right     (x_right),
    .x_left      (x_left),
    .y_down      (y_down),
    .y_up        (y_up),
    .last_point  (last_point)
  );

  // an update never overwrites an untaken beat
  assert property (@(posedge clk) disable iff (rst) !(cmd.update && sts.out_busy))
    else $error("update while output register busy");

  // no step work while the input side is open
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!cmd.update && !cmd.decide))
    else $error("step command while accepting input");

  // a start passes through the square, product and init states before input opens again
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && opcode == OP_START) |=>
      !in_ready ##1 !in_ready ##1 !in_ready ##1 in_ready)
    else $error("start sequence length wrong");

  // a new output beat only comes from an update
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.update))
    else $error("output beat without update");

endmodule

`default_nettype wire

### tb/sv/tb.sv
// tb: self-checking bench for bresenham_ellipse_raster, directed table then random beats.
// Depends on ber_pkg and the bresenham_ellipse_raster top level; no other files.

module tb;
  import ber_pkg::*;

  localparam int TOTAL_ITEMS  = 1300;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AT_1    = 3000;
  localparam int HOLD_AT_2    = 8000;

  typedef enum logic [1:0] {
    CHECK_MODEL,
    CHECK_NONE,
    CHECK_TYPED
  } check_kind_e;

  typedef struct packed {
    logic [OUT_BITS-1:0]        x_right;
    logic signed [OUT_BITS-1:0] x_left;
    logic [OUT_BITS-1:0]        y_down;
    logic signed [OUT_BITS-1:0] y_up;
    logic                       last_point;
  } point_t;

  typedef struct packed {
    check_kind_e           kind;
    logic                  op;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [AXIS_BITS-1:0]  ax;
    logic [AXIS_BITS-1:0]  ay;
    point_t                want;
  } stim_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        opcode = OP_START;
  logic [COORD_BITS-1:0]       center_x = '0;
  logic [COORD_BITS-1:0]       center_y = '0;
  logic [AXIS_BITS-1:0]        semi_axis_x = '0;
  logic [AXIS_BITS-1:0]        semi_axis_y = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [OUT_BITS-1:0]         x_right;
  logic signed [OUT_BITS-1:0]  x_left;
  logic [OUT_BITS-1:0]         y_down;
  logic signed [OUT_BITS-1:0]  y_up;
  logic                        last_point;

  // ellipse tracker state
  bit     ell_active = 1'b0;
  longint ctr_x = 0;
  longint ctr_y = 0;
  longint off_x = 0;
  longint off_y = 0;
  longint err_acc = 0;
  longint a_sq = 0;
  longint b_sq = 0;

  point_t    pending_points[$];
  stim_row_t dir_rows[$];

  int cycle_count = 0;
  int failures = 0;
  int stim_items = 0;
  int starts_sent = 0;
  int points_checked = 0;
  int ellipses_closed = 0;
  int tx_calm = 0;
  int rx_calm = 0;
  int rx_stall = 0;
  int rx_cycles = 0;
  point_t seen_point;

  bresenham_ellipse_raster dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .center_x   (center_x),
    .center_y   (center_y),
    .semi_axis_x(semi_axis_x),
    .semi_axis_y(semi_axis_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .x_right    (x_right),
    .x_left     (x_left),
    .y_down     (y_down),
    .y_up       (y_up),
    .last_point (last_point)
  );

  // clock, period 10
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("bresenham_ellipse_raster test failed");
      $finish;
    end
  end

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // advance the tracked ellipse by one beat; returns 1 when a point set comes out
  function automatic bit advance_ellipse(input stim_row_t item, output point_t pt);
    longint x, y, e, d, s;
    pt = '0;
    if (item.op == OP_START) begin
      x = longint'(item.ax);
      y = longint'(item.ay);
      ctr_x = longint'(item.cx);
      ctr_y = longint'(item.cy);
      a_sq = x * x;
      b_sq = y * y;
      off_x = 0;
      off_y = y;
      err_acc = a_sq + b_sq - 2 * a_sq * y;
      ell_active = 1'b1;
      return 1'b0;
    end
    if (!ell_active) return 1'b0;

    x = off_x;
    y = off_y;
    e = err_acc;
    s = ctr_x + x;
    pt.x_right = s[OUT_BITS-1:0];
    s = ctr_x - x;
    pt.x_left = s[OUT_BITS-1:0];
    s = ctr_y + y;
    pt.y_down = s[OUT_BITS-1:0];
    s = ctr_y - y;
    pt.y_up = s[OUT_BITS-1:0];

    // move choice by sign of error, then of the decision value
    if (e < 0) begin
      d = 2 * (e + a_sq * y) - a_sq;
      x = x + 1;
      if (d < 0) begin
        e = e + b_sq * (2 * x + 1);
      end else begin
        y = y - 1;
        e = e + 2 * (b_sq * x - a_sq * y) + a_sq + b_sq;
      end
    end else if (e > 0) begin
      d = 2 * (e - b_sq * x) - b_sq;
      y = y - 1;
      if (d > 0) begin
        e = e - a_sq * (2 * y - 1);
      end else begin
        x = x + 1;
        e = e + 2 * (b_sq * x - a_sq * y) + a_sq + b_sq;
      end
    end else begin
      x = x + 1;
      y = y - 1;
      e = e + 2 * (b_sq * x - a_sq * y) + a_sq + b_sq;
    end

    pt.last_point = (y < 0);
    if (y < 0) begin
      ell_active = 1'b0;
      off_x = 0;
      off_y = 0;
      err_acc = 0;
    end else begin
      off_x = x;
      off_y = y;
      err_acc = e;
    end
    return 1'b1;
  endfunction

  // one directed row
  task automatic add_row(input check_kind_e kind, input logic op, input int cx, input int cy,
                         input int ax, input int ay, input int xr, input int xl,
                         input int yd, input int yu, input logic last);
    stim_row_t row;
    row.kind = kind;
    row.op = op;
    row.cx = cx[COORD_BITS-1:0];
    row.cy = cy[COORD_BITS-1:0];
    row.ax = ax[AXIS_BITS-1:0];
    row.ay = ay[AXIS_BITS-1:0];
    row.want.x_right = xr[OUT_BITS-1:0];
    row.want.x_left = xl[OUT_BITS-1:0];
    row.want.y_down = yd[OUT_BITS-1:0];
    row.want.y_up = yu[OUT_BITS-1:0];
    row.want.last_point = last;
    dir_rows.push_back(row);
  endtask

  // offer one beat, called at a rising edge; returns at the edge that takes it
  task automatic send_item(input stim_row_t item);
    int gap;
    bit produced;
    point_t pt;
    if (tx_calm > 0) begin
      tx_calm--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 29) == 0) tx_calm = $urandom_range(20, 60);
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= item.op;
    center_x    <= item.cx;
    center_y    <= item.cy;
    semi_axis_x <= item.ax;
    semi_axis_y <= item.ay;
    do @(posedge clk); while (!in_ready);

    produced = advance_ellipse(item, pt);
    if (item.op == OP_START) starts_sent++;
    stim_items++;
    case (item.kind)
      CHECK_MODEL: if (produced) pending_points.push_back(pt);
      CHECK_TYPED: pending_points.push_back(item.want);
      default: ;
    endcase
  endtask

  // random beat: random payload everywhere, the chosen opcode
  task automatic send_random(input logic op);
    stim_row_t row;
    logic [31:0] rnd;
    row = '0;
    row.kind = CHECK_MODEL;
    row.op = op;
    rnd = $urandom;
    row.cx = rnd[COORD_BITS-1:0];
    rnd = $urandom;
    row.cy = rnd[COORD_BITS-1:0];
    rnd = $urandom;
    row.ax = rnd[AXIS_BITS-1:0];
    rnd = $urandom;
    row.ay = rnd[AXIS_BITS-1:0];
    send_item(row);
  endtask

  // receiver: check each beat, random stalls plus two long holds
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen_point.x_right = x_right;
      seen_point.x_left = x_left;
      seen_point.y_down = y_down;
      seen_point.y_up = y_up;
      seen_point.last_point = last_point;
      if (pending_points.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected beat: x_right=%0d x_left=%0d y_down=%0d y_up=%0d last=%0b",
                   x_right, x_left, y_down, y_up, last_point);
      end else begin
        if (seen_point !== pending_points[0]) begin
          failures++;
          if (failures <= 10)
            $display("mismatch: expected %0d %0d %0d %0d last=%0b, got %0d %0d %0d %0d last=%0b",
                     pending_points[0].x_right, pending_points[0].x_left,
                     pending_points[0].y_down, pending_points[0].y_up,
                     pending_points[0].last_point, x_right, x_left, y_down, y_up,
                     last_point);
        end
        void'(pending_points.pop_front());
        points_checked++;
        if (last_point) ellipses_closed++;
      end
    end

    rx_cycles++;
    if (rx_cycles == HOLD_AT_1 || rx_cycles == HOLD_AT_2) rx_stall = LONG_HOLD;
    if (rx_stall > 0) begin
      rx_stall--;
      out_ready <= 1'b0;
    end else begin
      if (rx_calm > 0) rx_calm--;
      else if ($urandom_range(0, 49) == 0) rx_calm = $urandom_range(20, 80);
      if (rx_calm == 0) rx_stall = pick_gap();
      out_ready <= (rx_stall == 0);
    end
  end

  // stimulus and end of run
  initial begin
    stim_row_t row;
    logic [31:0] rnd;
    int shape, sz, step_cap, n;

    // directed rows: idle step, zero axes, extremes, restart while running
    add_row(CHECK_NONE,  OP_STEP,     0,    0,    0,    0,    0,    0,    0,    0, 1'b0);
    add_row(CHECK_NONE,  OP_START,  100,  200,    0,    0,    0,    0,    0,    0, 1'b0);
    add_row(CHECK_TYPED, OP_STEP,  4095, 4095, 2047, 2047,  100,  100,  200,  200, 1'b1);
    add_row(CHECK_NONE,  OP_STEP,     0,    0,    0,    0,    0,    0,    0,    0, 1'b0);
    add_row(CHECK_NONE,  OP_START, 4095, 4095,    5,    0,    0,    0,    0,    0, 1'b0);
    add_row(CHECK_TYPED, OP_STEP,     0,    0,    0,    0, 4095, 4095, 4095, 4095, 1'b1);
    add_row(CHECK_NONE,  OP_START,    0,    0,    3,    2,    0,    0,    0,    0, 1'b0);
    add_row(CHECK_TYPED, OP_STEP,     0,    0,    0,    0,    0,    0,    2,   -2, 1'b0);
    repeat (6)
      add_row(CHECK_MODEL, OP_STEP, 4095, 0, 2047, 0, 0, 0, 0, 0, 1'b0);
    add_row(CHECK_NONE,  OP_START,    0, 4095, 2047, 2047,    0,    0,    0,    0, 1'b0);
    add_row(CHECK_TYPED, OP_STEP,     0,    0,    0,    0,    0,    0, 6142, 2048, 1'b0);
    repeat (2)
      add_row(CHECK_MODEL, OP_STEP, 0, 4095, 0, 2047, 0, 0, 0, 0, 1'b0);
    add_row(CHECK_NONE,  OP_START, 4095,    0, 2047,    1,    0,    0,    0,    0, 1'b0);
    add_row(CHECK_TYPED, OP_STEP,     0,    0,    0,    0, 4095, 4095,    1,   -1, 1'b0);
    repeat (2)
      add_row(CHECK_MODEL, OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
    add_row(CHECK_NONE,  OP_START,    1,    2,    1, 2047,    0,    0,    0,    0, 1'b0);
    repeat (2)
      add_row(CHECK_MODEL, OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_item(dir_rows[i]);

    // random part: mostly complete ellipses, some broken ones, stray steps and stray starts
    while (stim_items < TOTAL_ITEMS) begin
      shape = $urandom_range(0, 99);
      if (shape < 80) begin
        row = '0;
        row.kind = CHECK_MODEL;
        row.op = OP_START;
        sz = $urandom_range(0, 99);
        rnd = $urandom;
        if (sz < 88) begin
          row.ax = AXIS_BITS'(rnd[3:0] % 13);
          row.ay = AXIS_BITS'(rnd[7:4] % 13);
        end else if (sz < 96) begin
          row.ax = AXIS_BITS'(rnd[5:0] % 41);
          row.ay = AXIS_BITS'(rnd[11:6] % 41);
        end else begin
          row.ax = rnd[AXIS_BITS-1:0];
          row.ay = rnd[2*AXIS_BITS-1:AXIS_BITS];
        end
        rnd = $urandom;
        row.cx = rnd[COORD_BITS-1:0];
        row.cy = rnd[2*COORD_BITS-1:COORD_BITS];
        if (rnd[27:24] == 4'd0) row.cx = '0;
        if (rnd[27:24] == 4'd1) row.cx = '1;
        if (rnd[31:28] == 4'd0) row.cy = '0;
        if (rnd[31:28] == 4'd1) row.cy = '1;
        send_item(row);

        step_cap = (sz >= 96) ? $urandom_range(1, 30) : 100000;
        if ($urandom_range(0, 19) == 0) step_cap = $urandom_range(0, 5);
        n = 0;
        while (ell_active && n < step_cap) begin
          send_random(OP_STEP);
          n++;
        end
        if (!ell_active && $urandom_range(0, 9) == 0) send_random(OP_STEP);
      end else if (shape < 90) begin
        send_random(OP_STEP);
      end else begin
        send_random(OP_START);
      end
    end
    in_valid <= 1'b0;

    // drain, then watch for stray beats
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d ellipse starts and %0d input beats in total", starts_sent, stim_items);
    $display("checked %0d point sets, %0d of them closing an ellipse", points_checked,
             ellipses_closed);
    if (failures == 0) begin
      $display("bresenham_ellipse_raster test passed");
    end else begin
      $display("%0d mismatches", failures);
      $display("bresenham_ellipse_raster test failed");
    end
    $finish;
  end

endmodule
